[design/assert_macros.svh]
// assert_macros.svh: assertion macros for the bounded deque checker.
// Clocked on clk; the first macro is also disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define BDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included
`define BDQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/bdq_pkg.sv]
// bdq_pkg: shared types, constants and ring arithmetic for the bounded deque.
// Used by the controller, the datapath, the top level and the checker.
package bdq_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    wr_front;
    logic    wr_back;
    logic    rd_front;
    logic    rd_back;
    logic    do_clear;
    logic    list_start;
    logic    list_step;
    logic    load_out;
    logic    out_from_mem;
    logic    out_last;
    status_t out_status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic list_last;
    logic out_free;
  } stat_t;

  // (idx + off) mod DEPTH, for off below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(idx) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

endpackage

[design/bdq_ctrl.sv]
// bdq_ctrl: controller state machine of the bounded deque.
// Depends on bdq_pkg; drives the datapath through cmd_t and reads stat_t.
module bdq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bdq_pkg::OP_W-1:0]   op,
  input  bdq_pkg::stat_t             st,
  output bdq_pkg::cmd_t              cmd
);
  import bdq_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = (state == S_IDLE) && in_valid && st.out_free;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((op == OP_POP_FRONT || op == OP_POP_BACK) && !st.empty) begin
            state_next = S_POP;
          end else if (op == OP_LIST && !st.empty) begin
            state_next = S_LIST;
          end
        end
      end
      S_POP: begin
        state_next = S_IDLE;
      end
      S_LIST: begin
        if (st.out_free && st.list_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = !st.out_free;
        if (accept) begin
          cmd.out_last = 1'b1;
          case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              cmd.load_out = 1'b1;
              if (st.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.out_status = ST_OK;
                cmd.wr_front   = (op == OP_PUSH_FRONT);
                cmd.wr_back    = (op == OP_PUSH_BACK);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (st.empty) begin
                cmd.load_out   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.rd_front = (op == OP_POP_FRONT);
                cmd.rd_back  = (op == OP_POP_BACK);
              end
            end
            OP_LIST: begin
              if (st.empty) begin
                cmd.load_out   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.list_start = 1'b1;
              end
            end
            OP_CLEAR: begin
              cmd.do_clear   = 1'b1;
              cmd.load_out   = 1'b1;
              cmd.out_status = ST_OK;
            end
            default: begin
              // unused codes: no state change, plain ok result
              cmd.load_out   = 1'b1;
              cmd.out_status = ST_OK;
            end
          endcase
        end
      end
      S_POP: begin
        // output register was free at accept, so it is empty now
        cmd.load_out     = 1'b1;
        cmd.out_from_mem = 1'b1;
        cmd.out_last     = 1'b1;
        cmd.out_status   = ST_OK;
      end
      S_LIST: begin
        if (st.out_free) begin
          cmd.load_out     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_last     = st.list_last;
          cmd.out_status   = ST_OK;
          cmd.list_step    = !st.list_last;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[design/bdq_dpath.sv]
// bdq_dpath: ring store, front/count registers, list walker and result register.
// Depends on bdq_pkg; controlled by bdq_ctrl through cmd_t.
module bdq_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bdq_pkg::DATA_W-1:0]    value,
  input  bdq_pkg::cmd_t                 cmd,
  output bdq_pkg::stat_t                st,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdq_pkg::DATA_W-1:0]    value_out,
  output logic [bdq_pkg::STAT_W-1:0]    status,
  output logic [bdq_pkg::COUNT_W-1:0]   item_count,
  output logic                          last
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic [IDX_W-1:0]  front, front_next;
  logic [CNT_W-1:0]  total, total_next;
  logic [CNT_W-1:0]  list_idx;
  logic [CNT_W-1:0]  list_idx_inc;

  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [IDX_W-1:0]  front_dec;

  assign front_dec    = ring_add(front, CNT_W'(DEPTH - 1));
  assign list_idx_inc = list_idx + 1'b1;

  // Status to controller
  assign st.empty     = (total == '0);
  assign st.full      = (total == CNT_W'(DEPTH));
  assign st.list_last = (list_idx_inc == total);
  assign st.out_free  = !out_valid || !out_stall;

  // Store addressing
  always_comb begin
    wr_en   = cmd.wr_front || cmd.wr_back;
    wr_addr = cmd.wr_front ? front_dec : ring_add(front, total);
    rd_en   = cmd.rd_front || cmd.rd_back || cmd.list_start || cmd.list_step;
    if (cmd.rd_back) begin
      rd_addr = ring_add(front, total - 1'b1);
    end else if (cmd.list_step) begin
      rd_addr = ring_add(front, list_idx_inc);
    end else begin
      rd_addr = front;
    end
  end

  // Ring store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Front and count update
  always_comb begin
    front_next = front;
    total_next = total;
    if (cmd.do_clear) begin
      front_next = '0;
      total_next = '0;
    end else if (cmd.wr_front || cmd.wr_back) begin
      total_next = total + 1'b1;
      if (cmd.wr_front) begin
        front_next = front_dec;
      end
    end else if (cmd.rd_front || cmd.rd_back) begin
      total_next = total - 1'b1;
      if (cmd.rd_front) begin
        front_next = ring_add(front, CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      total <= '0;
    end else begin
      front <= front_next;
      total <= total_next;
    end
  end

  // List walker offset
  always_ff @(posedge clk) begin
    if (cmd.list_start) begin
      list_idx <= '0;
    end else if (cmd.list_step) begin
      list_idx <= list_idx_inc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      value_out  <= cmd.out_from_mem ? rd_data : '0;
      status     <= STAT_W'(cmd.out_status);
      item_count <= COUNT_W'(total_next);
      last       <= cmd.out_last;
    end
  end

endmodule

[design/bounded_deque_top.sv]
// bounded_deque_top: double-ended queue of 32-bit values in a ring store.
// Instantiates bdq_ctrl and bdq_dpath; types and constants from bdq_pkg.
//
//   channel  direction  handshake           payload
//   input    in         in_valid/in_stall   op, value
//   result   out        out_valid/out_stall value_out, status, item_count, last
//
// Push, clear and unused op codes load their result at accept; a pop goes
// through S_POP, since the ring store's read port is registered. List walks
// the elements in S_LIST, all reads going through that single read port.
// Reset (rst, synchronous) clears the front index, the count and the result
// valid; the store itself is not cleared and needs no clearing pass.
// A stalled result holds; a new transaction is taken in S_IDLE once the result
// register is empty or draining in the same cycle.
module bounded_deque_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bdq_pkg::OP_W-1:0]      op,
  input  logic [bdq_pkg::DATA_W-1:0]    value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdq_pkg::DATA_W-1:0]    value_out,
  output logic [bdq_pkg::STAT_W-1:0]    status,
  output logic [bdq_pkg::COUNT_W-1:0]   item_count,
  output logic                          last
);
  import bdq_pkg::*;

  cmd_t  cmd;
  stat_t st;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .st       (st),
    .cmd      (cmd)
  );

  bdq_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value_out  (value_out),
    .status     (status),
    .item_count (item_count),
    .last       (last)
  );

endmodule

[design/bdq_checker.sv]
// bdq_port_checker: port-level checks of the bounded deque, bound to the top level.
// Depends on bdq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bdq_port_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [bdq_pkg::OP_W-1:0]      op,
  input logic [bdq_pkg::DATA_W-1:0]    value,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bdq_pkg::DATA_W-1:0]    value_out,
  input logic [bdq_pkg::STAT_W-1:0]    status,
  input logic [bdq_pkg::COUNT_W-1:0]   item_count,
  input logic                          last
);
  import bdq_pkg::*;

  logic                             full_res, empty_res;
  logic [OP_W+DATA_W-1:0]           in_bits;
  logic [DATA_W+STAT_W+COUNT_W:0]   out_bits;

  assign full_res  = out_valid && (status == STAT_W'(ST_FULL));
  assign empty_res = out_valid && (status == STAT_W'(ST_EMPTY));
  assign in_bits   = {op, value};
  assign out_bits  = {value_out, status, item_count, last};

  // a stalled input transaction holds its payload
  `BDQ_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_bits), "stalled input changed")

  // a stalled result transaction holds its payload
  `BDQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_bits), "stalled result changed")

  // a dropped push only happens on a full queue and returns no data
  `BDQ_ASSERT(a_full_res, full_res |-> (item_count == COUNT_W'(DEPTH)) && (value_out == '0) && last, "bad full result")

  // an empty result reports an empty queue and ends its transaction
  `BDQ_ASSERT(a_empty_res, empty_res |-> (item_count == '0) && (value_out == '0) && last, "bad empty result")

  // no result survives reset
  `BDQ_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid, "result valid after reset")

endmodule

bind bounded_deque_top bdq_port_checker u_bdq_checker (.*);

[tb/bdq_checker.sv]
`timescale 1ns / 100ps
// bdq_checker.sv: predicts the bounded deque from the accepted input transactions
// and compares every accepted result transaction, field by field, in order.
// Depends on bdq_pkg for widths, op codes and status codes.
module bdq_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [bdq_pkg::OP_W-1:0]    op,
  input  logic [bdq_pkg::DATA_W-1:0]  value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [bdq_pkg::DATA_W-1:0]  value_out,
  input  logic [bdq_pkg::STAT_W-1:0]  status,
  input  logic [bdq_pkg::COUNT_W-1:0] item_count,
  input  logic                        last,
  output int                          error_total,
  output int                          pending_total
);
  import bdq_pkg::*;

  typedef struct {
    logic [DATA_W-1:0]  data;
    status_t            stat;
    logic [COUNT_W-1:0] count;
    logic               fin;
  } deque_result_t;

  // Shadow copy of the ring contents, front position and occupancy
  logic [DATA_W-1:0] shadow_ring [DEPTH];
  int                shadow_head;
  int                shadow_fill;
  deque_result_t     expected_q[$];

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    error_total++;
  endtask

  // Queue one expected result; the count is the occupancy after the operation
  task automatic add_result(input logic [DATA_W-1:0] data, input status_t stat,
                            input logic fin);
    deque_result_t res;
    res.data  = data;
    res.stat  = stat;
    res.count = COUNT_W'(shadow_fill);
    res.fin   = fin;
    expected_q.push_back(res);
  endtask

  // Apply one operation to the shadow deque and queue what it should produce
  task automatic predict_deque_op(input logic [OP_W-1:0] code,
                                  input logic [DATA_W-1:0] data);
    int pos;
    case (code)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          add_result('0, ST_FULL, 1'b1);
        end else begin
          if (code == OP_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_ring[shadow_head] = data;
          end else begin
            shadow_ring[(shadow_head + shadow_fill) % DEPTH] = data;
          end
          shadow_fill++;
          add_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_fill == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          if (code == OP_POP_FRONT) begin
            pos = shadow_head;
            shadow_head = (shadow_head + 1) % DEPTH;
          end else begin
            pos = (shadow_head + shadow_fill - 1) % DEPTH;
          end
          shadow_fill--;
          add_result(shadow_ring[pos], ST_OK, 1'b1);
        end
      end
      OP_LIST: begin
        if (shadow_fill == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (pos = 0; pos < shadow_fill; pos++) begin
            add_result(shadow_ring[(shadow_head + pos) % DEPTH], ST_OK,
                       pos == shadow_fill - 1);
          end
        end
      end
      OP_CLEAR: begin
        shadow_head = 0;
        shadow_fill = 0;
        add_result('0, ST_OK, 1'b1);
      end
      // unused op codes leave the deque alone
      default: begin
        add_result('0, ST_OK, 1'b1);
      end
    endcase
  endtask

  // Results are checked before the same edge's input is predicted
  always @(posedge clk) begin : watch_channels
    deque_result_t want;
    if (rst) begin
      shadow_head = 0;
      shadow_fill = 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result transaction", value_out, '0);
        end else begin
          want = expected_q.pop_front();
          if (value_out !== want.data) begin
            report_mismatch("value_out", value_out, want.data);
          end
          if (status !== want.stat) begin
            report_mismatch("status", DATA_W'(status), DATA_W'(want.stat));
          end
          if (item_count !== want.count) begin
            report_mismatch("item_count", DATA_W'(item_count), DATA_W'(want.count));
          end
          if (last !== want.fin) begin
            report_mismatch("last", DATA_W'(last), DATA_W'(want.fin));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_deque_op(op, value);
      end
    end
    pending_total = expected_q.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// testbench.sv: drives op/value transactions into bounded_deque_top with random
// idling on both channels and gives the verdict; checking is done by bdq_checker.
// Depends on bdq_pkg, bounded_deque_top and bdq_checker.
module testbench;
  import bdq_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_AT      = 200;
  localparam int PAUSE_AT     = 320;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  // burst flavors for the random part
  localparam int BURST_FILL  = 0;
  localparam int BURST_DRAIN = 1;
  localparam int BURST_MIXED = 2;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    op = '0;
  logic [DATA_W-1:0]  value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DATA_W-1:0]  value_out;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] item_count;
  logic               last;
  int                 error_total;
  int                 pending_total;
  int                 items_sent = 0;
  logic               hold_req = 1'b0;
  logic               calm = 1'b0;

  bounded_deque_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value_out  (value_out),
    .status     (status),
    .item_count (item_count),
    .last       (last)
  );

  bdq_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .value_out     (value_out),
    .status        (status),
    .item_count    (item_count),
    .last          (last),
    .error_total   (error_total),
    .pending_total (pending_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random word, biased toward the extremes
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] spare_op();
    return $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int flavor);
    int r;
    r = $urandom_range(0, 99);
    case (flavor)
      BURST_FILL: begin
        if (r < 42) return OP_PUSH_FRONT;
        if (r < 84) return OP_PUSH_BACK;
        if (r < 90) return OP_POP_FRONT;
        if (r < 95) return OP_POP_BACK;
        if (r < 98) return OP_LIST;
        return spare_op();
      end
      BURST_DRAIN: begin
        if (r < 8)  return OP_PUSH_FRONT;
        if (r < 16) return OP_PUSH_BACK;
        if (r < 55) return OP_POP_FRONT;
        if (r < 94) return OP_POP_BACK;
        if (r < 97) return OP_LIST;
        return spare_op();
      end
      default: begin
        if (r < 23) return OP_PUSH_FRONT;
        if (r < 46) return OP_PUSH_BACK;
        if (r < 68) return OP_POP_FRONT;
        if (r < 90) return OP_POP_BACK;
        if (r < 95) return OP_LIST;
        if (r < 98) return OP_CLEAR;
        return spare_op();
      end
    endcase
  endfunction

  // Offer one transaction after a random gap (none when calm) and hold it until accepted
  task automatic send_op(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] data);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    value    <= data;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_total == 0);
    @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_side
    int n;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat (($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin : input_side
    int flavor;
    int burst;
    int stop_at;
    bit hold_done;
    bit paused;
    hold_done = 1'b0;
    paused    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cases, extremes, every op, unused codes
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_LIST, '0);
    send_op(OP_SPARE_LO, 32'hFFFF_FFFF);
    send_op(OP_SPARE_HI, '0);
    send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_op(OP_PUSH_BACK, 32'h8000_0000);
    send_op(OP_PUSH_FRONT, 32'h0000_0000);
    send_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_op(OP_PUSH_FRONT, 32'h5555_5555);
    send_op(OP_PUSH_BACK, 32'hAAAA_AAAA);
    send_op(OP_LIST, '0);
    send_op(OP_SPARE_HI, 32'h1234_5678);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_CLEAR, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_LIST, '0);
    stop_at = items_sent + RANDOM_ITEMS;

    // fill past full with wraparound, list the full ring, then drain past empty
    repeat (DEPTH + 3) begin
      send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word());
    end
    send_op(OP_LIST, '0);
    repeat (DEPTH + 2) begin
      send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, rand_word());
    end

    // random bursts that swing the occupancy between empty and full
    while (items_sent < stop_at) begin
      flavor = $urandom_range(BURST_FILL, BURST_MIXED);
      burst  = $urandom_range(10, 50);
      calm   = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        if (!hold_done && items_sent >= HOLD_AT) begin
          hold_done = 1'b1;
          hold_req  = 1'b1;
        end
        if (!paused && items_sent >= PAUSE_AT) begin
          paused = 1'b1;
          wait_all_results();
        end
        send_op(pick_op(flavor), rand_word());
      end
    end
    calm = 1'b0;

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_total == 0 && pending_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
